[hw/rtl/btmx_pkg.sv]
// Package for the binary trie maximum-XOR block: sizes, codes and shared types.
// No dependencies; every other file of the block refers to it by scoped names.
`timescale 1ns / 1ps

package btmx_pkg;

  // Field widths of the item interfaces.
  localparam int unsigned VALUE_W  = 31;
  localparam int unsigned STATUS_W = 2;

  // Trie geometry.
  localparam int unsigned KEY_BITS   = 31;
  localparam int unsigned NODE_COUNT = 32768;
  localparam int unsigned NODE_W     = $clog2(NODE_COUNT);
  localparam int unsigned CNT_W      = $clog2(NODE_COUNT + 1);
  localparam int unsigned SUM_W      = CNT_W + 1;
  localparam int unsigned POS_W      = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_QUERY  = 1'b1
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_ALLOC,
    S_DONE
  } state_e;

  // One row of the node table: the child reached on a one bit and on a zero bit.
  // A link of zero means no child, as the root is never anybody's child.
  typedef struct packed {
    logic [NODE_W-1:0] hi;
    logic [NODE_W-1:0] lo;
  } links_t;

  typedef struct packed {
    logic              we;
    logic [NODE_W-1:0] waddr;
    links_t            wdata;
    logic [NODE_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic                valid;
    logic [VALUE_W-1:0]  max_xor;
    status_e             status;
  } result_t;

endpackage

[hw/rtl/btmx_if.sv]
// Item channel interfaces of the binary trie maximum-XOR block.
// Depends on btmx_pkg for the field widths.
`timescale 1ns / 1ps

interface btmx_req_if;
  logic                          valid;
  logic                          ready;
  logic                          cmd;
  logic [btmx_pkg::VALUE_W-1:0]  value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface btmx_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [btmx_pkg::VALUE_W-1:0]  max_xor;
  logic [btmx_pkg::STATUS_W-1:0] status;

  modport source (output valid, output max_xor, output status, input ready);
  modport sink   (input valid, input max_xor, input status, output ready);
endinterface

[hw/rtl/btmx_node_mem.sv]
// Node table of the trie: one write port and one registered read port.
// Depends on btmx_pkg for the row type and the table depth.
`timescale 1ns / 1ps

module btmx_node_mem (
  input  logic               clk_i,
  input  btmx_pkg::mem_req_t req_i,
  output btmx_pkg::links_t   rdata_o
);

  btmx_pkg::links_t mem_q [btmx_pkg::NODE_COUNT];
  btmx_pkg::links_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/btmx_ctrl.sv]
// Sequencer of the trie walk: one trie level per cycle through the node table.
// Depends on btmx_pkg; drives btmx_node_mem through a request struct.
`timescale 1ns / 1ps

module btmx_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           req_valid_i,
  input  logic                           req_cmd_i,
  input  logic [btmx_pkg::VALUE_W-1:0]   req_value_i,
  output logic                           req_ready_o,
  input  logic                           res_free_i,
  output btmx_pkg::result_t              res_o,
  output btmx_pkg::mem_req_t             mem_req_o,
  input  btmx_pkg::links_t               mem_rdata_i
);

  btmx_pkg::state_e               state_q, state_d;
  logic                           cmd_q, cmd_d;
  logic [btmx_pkg::KEY_BITS-1:0]  key_q, key_d;
  logic [btmx_pkg::KEY_BITS-1:0]  best_q, best_d;
  logic [btmx_pkg::NODE_W-1:0]    node_q, node_d;
  logic [btmx_pkg::POS_W-1:0]     pos_q, pos_d;
  logic [btmx_pkg::CNT_W-1:0]     used_q, used_d;
  logic                           present_q, present_d;
  btmx_pkg::status_e              status_q, status_d;

  btmx_pkg::links_t               links;
  logic                           bit_cur;
  logic [btmx_pkg::NODE_W-1:0]    same_l;
  logic [btmx_pkg::NODE_W-1:0]    opp_l;
  logic [btmx_pkg::NODE_W-1:0]    new_node;
  logic                           last;
  logic [btmx_pkg::SUM_W-1:0]     need_sum;
  logic                           full;
  logic                           accept;
  logic                           is_query;

  // The root row is never written before the first key goes in, so it reads
  // as empty until then.
  assign links    = (node_q == '0 && !present_q) ? '0 : mem_rdata_i;
  assign bit_cur  = key_q[pos_q];
  assign same_l   = bit_cur ? links.hi : links.lo;
  assign opp_l    = bit_cur ? links.lo : links.hi;
  assign new_node = btmx_pkg::NODE_W'(used_q);
  assign last     = (pos_q == '0);
  assign need_sum = {1'b0, used_q} + btmx_pkg::SUM_W'(pos_q) + btmx_pkg::SUM_W'(1);
  assign full     = need_sum > btmx_pkg::SUM_W'(btmx_pkg::NODE_COUNT);
  assign accept   = req_valid_i && (state_q == btmx_pkg::S_IDLE);
  assign is_query = (cmd_q == btmx_pkg::CMD_QUERY);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      btmx_pkg::S_IDLE: begin
        if (req_valid_i) begin
          if (req_cmd_i == btmx_pkg::CMD_QUERY && !present_q) begin
            state_d = btmx_pkg::S_DONE;
          end else begin
            state_d = btmx_pkg::S_WALK;
          end
        end
      end
      btmx_pkg::S_WALK: begin
        if (is_query) begin
          if ((opp_l == '0 && same_l == '0) || last) begin
            state_d = btmx_pkg::S_DONE;
          end
        end else if (same_l != '0) begin
          if (last) begin
            state_d = btmx_pkg::S_DONE;
          end
        end else if (full || last) begin
          state_d = btmx_pkg::S_DONE;
        end else begin
          state_d = btmx_pkg::S_ALLOC;
        end
      end
      btmx_pkg::S_ALLOC: begin
        if (last) begin
          state_d = btmx_pkg::S_DONE;
        end
      end
      btmx_pkg::S_DONE: begin
        if (res_free_i) begin
          state_d = btmx_pkg::S_IDLE;
        end
      end
      default: state_d = btmx_pkg::S_IDLE;
    endcase
  end

  // Datapath next values.
  always_comb begin
    cmd_d     = cmd_q;
    key_d     = key_q;
    best_d    = best_q;
    node_d    = node_q;
    pos_d     = pos_q;
    used_d    = used_q;
    present_d = present_q;
    status_d  = status_q;
    case (state_q)
      btmx_pkg::S_IDLE: begin
        if (accept) begin
          cmd_d    = req_cmd_i;
          key_d    = btmx_pkg::KEY_BITS'(req_value_i);
          best_d   = '0;
          node_d   = '0;
          pos_d    = btmx_pkg::POS_W'(btmx_pkg::KEY_BITS - 1);
          status_d = (req_cmd_i == btmx_pkg::CMD_QUERY && !present_q) ?
                     btmx_pkg::ST_EMPTY : btmx_pkg::ST_OK;
        end
      end
      btmx_pkg::S_WALK: begin
        pos_d = pos_q - btmx_pkg::POS_W'(1);
        if (is_query) begin
          if (opp_l != '0) begin
            best_d[pos_q] = 1'b1;
            node_d        = opp_l;
          end else begin
            node_d = same_l;
          end
        end else if (same_l != '0) begin
          node_d = same_l;
          if (last) begin
            present_d = 1'b1;
          end
        end else if (full) begin
          status_d = btmx_pkg::ST_FULL;
        end else begin
          node_d = new_node;
          used_d = used_q + btmx_pkg::CNT_W'(1);
          if (last) begin
            present_d = 1'b1;
          end
        end
      end
      btmx_pkg::S_ALLOC: begin
        pos_d  = pos_q - btmx_pkg::POS_W'(1);
        node_d = new_node;
        used_d = used_q + btmx_pkg::CNT_W'(1);
        if (last) begin
          present_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Outputs: memory request, handshake and result.
  always_comb begin
    mem_req_o.we    = 1'b0;
    mem_req_o.waddr = node_q;
    mem_req_o.wdata = links;
    mem_req_o.raddr = node_d;
    req_ready_o     = 1'b0;
    res_o.valid     = 1'b0;
    res_o.max_xor   = btmx_pkg::VALUE_W'(best_q);
    res_o.status    = status_q;
    unique case (state_q)
      btmx_pkg::S_IDLE: begin
        req_ready_o = 1'b1;
      end
      btmx_pkg::S_WALK: begin
        // Hook the first new node onto an existing one, keeping its other link.
        if (!is_query && same_l == '0 && !full) begin
          mem_req_o.we = 1'b1;
          if (bit_cur) begin
            mem_req_o.wdata.hi = new_node;
          end else begin
            mem_req_o.wdata.lo = new_node;
          end
        end
      end
      btmx_pkg::S_ALLOC: begin
        // A freshly allocated node has no other child yet.
        mem_req_o.we    = 1'b1;
        mem_req_o.wdata = '0;
        if (bit_cur) begin
          mem_req_o.wdata.hi = new_node;
        end else begin
          mem_req_o.wdata.lo = new_node;
        end
      end
      btmx_pkg::S_DONE: begin
        res_o.valid = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= btmx_pkg::S_IDLE;
      used_q    <= btmx_pkg::CNT_W'(1);
      present_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      used_q    <= used_d;
      present_q <= present_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    key_q    <= key_d;
    best_q   <= best_d;
    node_q   <= node_d;
    pos_q    <= pos_d;
    status_q <= status_d;
  end

endmodule

[hw/rtl/binary_trie_max_xor.sv]
// Binary trie maximum-XOR block: an insert or a query is accepted, walks the trie one key level
// at a time and is then handed over; a query on an empty trie or a refused insert finishes
// sooner. The single read port of the node table sets this pace, as each trie level needs the
// row fetched for the level above.
// Reset sets the node count back to one, the root, and clears the key flag at once; the node
// table gets no clearing pass, because a walk only uses the links of a row once they are written.
`timescale 1ns / 1ps

module binary_trie_max_xor (
  input  logic         clk_i,
  input  logic         rst_ni,
  btmx_req_if.sink     req_i,
  btmx_rsp_if.source   rsp_o
);

  // The sequencer walks the trie from the top key bit downwards. A query
  // prefers the branch opposite to its own bit and sets the matching bit of
  // the result when it can take it. An insert follows its own bits until a
  // link is missing, checks that the remaining levels fit in the table, and
  // then allocates one node per remaining level, writing one row a cycle.
  btmx_pkg::mem_req_t mem_req;
  btmx_pkg::links_t   mem_rdata;
  btmx_pkg::result_t  res;
  logic               res_free;

  // The result register parts the two sides: a finished item may wait here
  // while the next item is already accepted and walking the trie.
  logic                          rsp_valid_q;
  logic [btmx_pkg::VALUE_W-1:0]  rsp_max_xor_q;
  logic [btmx_pkg::STATUS_W-1:0] rsp_status_q;

  assign res_free = !rsp_valid_q || rsp_o.ready;

  btmx_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_cmd_i   (req_i.cmd),
    .req_value_i (req_i.value),
    .req_ready_o (req_i.ready),
    .res_free_i  (res_free),
    .res_o       (res),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  btmx_node_mem u_node_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (res.valid && res_free) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  // Payload is loaded only together with the valid flag.
  always_ff @(posedge clk_i) begin
    if (res.valid && res_free) begin
      rsp_max_xor_q <= res.max_xor;
      rsp_status_q  <= res.status;
    end
  end

  assign rsp_o.valid   = rsp_valid_q;
  assign rsp_o.max_xor = rsp_max_xor_q;
  assign rsp_o.status  = rsp_status_q;

endmodule

[verif/tb_top.sv]
// Self-checking testbench for the binary trie maximum-XOR block.
// It depends on btmx_pkg, on the item interfaces in btmx_if.sv and on the binary_trie_max_xor
// top level. It keeps its own copy of the trie to predict every status and maximum XOR.
`timescale 1ns / 1ps

module tb_top;
  import btmx_pkg::*;

  // One predicted reply. Both fields are compared one by one.
  typedef struct {
    logic [VALUE_W-1:0] max_xor;
    status_e            status;
  } reply_t;

  // Mirror of the trie. It predicts replies and holds the replies still due. The node table
  // follows the block's convention: a link of zero means no child, because the root, node 0,
  // never hangs below another node.
  class trie_tracker;
    int unsigned        child [NODE_COUNT][2];
    int unsigned        nodes_used = 1;
    bit                 key_present;
    bit                 full_seen;
    logic [VALUE_W-1:0] key_log [$];
    reply_t             awaited_replies [$];
    int unsigned        errors;
    int unsigned        replies;

    task report(string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      errors++;
    endtask

    // Number of nodes that an insert of this key would have to allocate.
    function int unsigned nodes_needed(logic [VALUE_W-1:0] key);
      int unsigned node;
      int unsigned nxt;
      node = 0;
      for (int pos = KEY_BITS - 1; pos >= 0; pos--) begin
        nxt = child[node][key[pos]];
        if (nxt == 0) return pos + 1;
        node = nxt;
      end
      return 0;
    endfunction

    function void store_key(logic [VALUE_W-1:0] key);
      int unsigned node;
      int unsigned nxt;
      node = 0;
      for (int pos = KEY_BITS - 1; pos >= 0; pos--) begin
        nxt = child[node][key[pos]];
        if (nxt == 0) begin
          nxt = nodes_used;
          nodes_used++;
          child[nxt][0] = 0;
          child[nxt][1] = 0;
          child[node][key[pos]] = nxt;
        end
        node = nxt;
      end
      key_present = 1'b1;
    endfunction

    // Greedy walk: take the branch opposite to the query bit wherever there is one.
    function logic [VALUE_W-1:0] best_xor(logic [VALUE_W-1:0] key);
      int unsigned        node;
      bit                 b;
      logic [VALUE_W-1:0] best;
      node = 0;
      best = '0;
      for (int pos = KEY_BITS - 1; pos >= 0; pos--) begin
        b = key[pos];
        if (child[node][!b] != 0) begin
          best[pos] = 1'b1;
          node = child[node][!b];
        end else if (child[node][b] != 0) begin
          node = child[node][b];
        end else begin
          break;
        end
      end
      return best;
    endfunction

    // Called for each input item at the edge that accepts it.
    function void note_command(cmd_e cmd, logic [VALUE_W-1:0] value);
      reply_t      rep;
      int unsigned need;
      rep.max_xor = '0;
      rep.status  = ST_OK;
      if (cmd == CMD_INSERT) begin
        need = nodes_needed(value);
        if (nodes_used + need > NODE_COUNT) begin
          rep.status = ST_FULL;
          full_seen  = 1'b1;
        end else begin
          if (need != 0) key_log.insert(key_log.size(), value);
          store_key(value);
        end
      end else if (!key_present) begin
        rep.status = ST_EMPTY;
      end else begin
        rep.max_xor = best_xor(value);
      end
      awaited_replies.insert(awaited_replies.size(), rep);
    endfunction

    // Called for each result item at the edge that accepts it.
    task check_reply(logic [VALUE_W-1:0] max_xor, logic [STATUS_W-1:0] status);
      reply_t rep;
      replies++;
      if (awaited_replies.size() == 0) begin
        report($sformatf("reply %0d arrived with nothing outstanding", replies));
      end else begin
        rep = awaited_replies.pop_front();
        if (status !== rep.status)
          report($sformatf("reply %0d status %0d, expected %0d",
                           replies, status, rep.status));
        if (max_xor !== rep.max_xor)
          report($sformatf("reply %0d max_xor %h, expected %h",
                           replies, max_xor, rep.max_xor));
      end
    endtask

    function int unsigned outstanding();
      return awaited_replies.size();
    endfunction

    function logic [VALUE_W-1:0] any_stored_key();
      return key_log[$urandom_range(0, key_log.size() - 1)];
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  bit   calm = 1'b0;   // While set, neither side starts a new idle gap or stall.

  btmx_req_if req_if ();
  btmx_rsp_if rsp_if ();

  trie_tracker tracker = new();

  binary_trie_max_xor dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always #5 clk = ~clk;

  // Idle length for either side: mostly none or short, now and then a long pause, so that gaps
  // land on every stage of the walk through the trie.
  function automatic int unsigned idle_cycles();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Sends one item. Valid stays high from one item to the next when there is no gap, so it is
  // never lowered and raised within the same time step. The mirror learns of the item at the
  // very edge that accepts it.
  task automatic send_command(input cmd_e cmd, input logic [VALUE_W-1:0] value);
    int unsigned gap;
    gap = idle_cycles();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.cmd   <= cmd;
    req_if.value <= value;
    do @(posedge clk); while (!req_if.ready);
    tracker.note_command(cmd, value);
  endtask

  // Directed opening: queries on the empty trie, the extreme keys, alternating bit patterns,
  // single-bit keys and duplicate inserts.
  task automatic run_directed();
    send_command(CMD_QUERY,  31'h0000_0000);
    send_command(CMD_QUERY,  31'h7FFF_FFFF);
    send_command(CMD_INSERT, 31'h0000_0000);
    send_command(CMD_QUERY,  31'h0000_0000);
    send_command(CMD_QUERY,  31'h7FFF_FFFF);
    send_command(CMD_INSERT, 31'h0000_0000);
    send_command(CMD_INSERT, 31'h7FFF_FFFF);
    send_command(CMD_QUERY,  31'h0000_0000);
    send_command(CMD_QUERY,  31'h7FFF_FFFF);
    send_command(CMD_INSERT, 31'h5555_5555);
    send_command(CMD_INSERT, 31'h2AAA_AAAA);
    send_command(CMD_QUERY,  31'h2AAA_AAAA);
    send_command(CMD_QUERY,  31'h5555_5555);
    send_command(CMD_INSERT, 31'h0000_0001);
    send_command(CMD_INSERT, 31'h4000_0000);
    send_command(CMD_QUERY,  31'h0000_0001);
    send_command(CMD_QUERY,  31'h3FFF_FFFF);
    send_command(CMD_INSERT, 31'h7FFF_FFFF);
    send_command(CMD_QUERY,  VALUE_W'($urandom()));
  endtask

  // Keys to insert. Until the table is full nearly all are fresh random keys, which fill the
  // node table with the fewest items. Afterwards most are duplicates and near neighbours of
  // stored keys, which need few or no new nodes and fill the table to the last node.
  function automatic logic [VALUE_W-1:0] insert_value();
    int unsigned        r;
    int unsigned        fresh;
    logic [VALUE_W-1:0] k;
    fresh = tracker.full_seen ? 40 : 95;
    r = $urandom_range(0, 99);
    if (r < fresh) return VALUE_W'($urandom());
    k = tracker.any_stored_key();
    if (r < fresh + (100 - fresh) / 2) return k;
    k[$urandom_range(0, 6)] ^= 1'b1;
    return k;
  endfunction

  // Query values: random ones, stored keys, their complements (where the best XOR is all ones
  // as the key itself is stored) and stored keys with a scrambled tail.
  function automatic logic [VALUE_W-1:0] query_value();
    int unsigned        r;
    logic [VALUE_W-1:0] k;
    r = $urandom_range(0, 99);
    if (r < 50) return VALUE_W'($urandom());
    k = tracker.any_stored_key();
    if (r < 70) return k;
    if (r < 85) return ~k;
    k[11:0] = 12'($urandom());
    return k;
  endfunction

  // Random part. Before the table is full almost every item is an insert. Once an insert has
  // been refused, the run goes on with an even mix for a while, so that refused inserts,
  // duplicates accepted at full capacity and queries on a packed trie all occur. The cap only
  // guards against a run in which no insert is ever refused.
  task automatic run_random();
    int unsigned        count;
    int unsigned        after_full;
    cmd_e               cmd;
    logic [VALUE_W-1:0] value;
    count      = 0;
    after_full = 0;
    while (!(tracker.full_seen && after_full >= 50) && count < 2000) begin
      if (count % 120 == 0) calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 99) < (tracker.full_seen ? 50 : 97)) begin
        cmd   = CMD_INSERT;
        value = insert_value();
      end else begin
        cmd   = CMD_QUERY;
        value = query_value();
      end
      send_command(cmd, value);
      count++;
      if (tracker.full_seen) after_full++;
    end
    calm = 1'b0;
  endtask

  // Result side. The handshake is sampled at the edge, then ready for the next edge is chosen.
  initial begin : reply_sink
    int unsigned hold;
    hold = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && rsp_if.valid && rsp_if.ready)
        tracker.check_reply(rsp_if.max_xor, rsp_if.status);
      if (hold == 0 && !calm && $urandom_range(0, 3) == 0) hold = idle_cycles();
      if (hold > 0) begin
        rsp_if.ready <= 1'b0;
        hold--;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    rst_n        = 1'b0;
    req_if.valid = 1'b0;
    req_if.cmd   = CMD_INSERT;
    req_if.value = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    run_random();
    // Lowered in the step of the last acceptance, so that no item is taken twice.
    req_if.valid <= 1'b0;

    // Wait for the last replies. Then allow about one walk through the trie for any reply that
    // should not come at all.
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (tracker.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // A correct run takes around a millisecond. This bound is well above that, even with every
  // gap and stall at its longest.
  initial begin : watchdog
    #10ms;
    $display("TIMEOUT: %0d replies still outstanding", tracker.outstanding());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
